FILE: hdl/hjd_pkg.sv
// Shared types and constants for the headset jack detect and button debounce block.
package hjd_pkg;

    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int TIMER_BITS_DEF = 16;

    localparam logic [CFG_W-1:0] INSERT_TICKS_RST = 16'd100;
    localparam logic [CFG_W-1:0] REMOVE_TICKS_RST = 16'd20;
    localparam logic [CFG_W-1:0] BUTTON_TICKS_RST = 16'd10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INSERT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REMOVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON = 2'd2;

    // jack kind codes
    localparam logic [1:0] JACK_NONE  = 2'd0;
    localparam logic [1:0] JACK_MIC   = 2'd1;
    localparam logic [1:0] JACK_NOMIC = 2'd2;

    typedef struct packed {
        logic       key_changed;
        logic       key_down;
        logic [1:0] jack_kind;
    } t_result;

endpackage

FILE: hdl/hjd_timer.sv
// Debounce countdown timer: load on restart, count down one per tick, flag expiry.
module hjd_timer #(
    parameter int TIMER_BITS = hjd_pkg::TIMER_BITS_DEF,
    parameter bit RUN_INIT   = 1'b0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_restart,
    input  logic                     i_tick,
    input  logic [hjd_pkg::CFG_W-1:0] i_len,
    output logic                     o_expire
);
    import hjd_pkg::*;

    localparam int LW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    logic [TIMER_BITS-1:0] r_count, n_count;
    logic                  r_run, n_run;
    logic [LW-1:0]         len_ext;
    logic [LW-1:0]         max_ext;
    logic [TIMER_BITS-1:0] len_c;
    logic                  at_end;

    // saturate the length to what the counter holds
    assign len_ext = LW'(i_len);
    assign max_ext = LW'({TIMER_BITS{1'b1}});
    assign len_c   = (len_ext > max_ext) ? max_ext[TIMER_BITS-1:0] : len_ext[TIMER_BITS-1:0];

    assign at_end   = (r_count <= TIMER_BITS'(1));
    assign o_expire = i_tick && r_run && at_end;

    always_comb begin
        n_count = r_count;
        n_run   = r_run;
        if (i_restart) begin
            n_count = len_c;
            n_run   = 1'b1;
        end else if (i_tick && r_run) begin
            if (at_end) begin
                n_count = '0;
                n_run   = 1'b0;
            end else begin
                n_count = r_count - TIMER_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_run   <= RUN_INIT;
        end else begin
            r_count <= n_count;
            r_run   <= n_run;
        end
    end

`ifndef SYNTH
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run |-> (r_count == '0))
        else $error("idle timer holds a nonzero count");
    a_expire_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_expire && !i_restart) |=> !r_run)
        else $error("timer still running after expiry");
    a_restart_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_restart |=> r_run)
        else $error("timer not running after restart");
`endif

endmodule

FILE: hdl/hjd_core.sv
// Jack and key state machine with detect and button debounce timers.
module hjd_core #(
    parameter int TIMER_BITS = hjd_pkg::TIMER_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_detect,
    input  logic                      i_button,
    input  logic [hjd_pkg::CFG_W-1:0] i_insert_len,
    input  logic [hjd_pkg::CFG_W-1:0] i_remove_len,
    input  logic [hjd_pkg::CFG_W-1:0] i_button_len,
    output hjd_pkg::t_result          o_result
);
    import hjd_pkg::*;

    logic [1:0] r_jack, n_jack;
    logic       r_key_held, n_key_held;
    logic       r_ignore, n_ignore;
    logic       r_prev_detect;
    logic       r_prev_button;

    logic       det_change, det_exp;
    logic       btn_change, btn_exp;
    logic       changed;
    logic [1:0] jack_mid;
    logic       key_mid, ign_mid;
    logic [CFG_W-1:0] det_len;

    assign det_change = (i_detect != r_prev_detect);
    assign det_len    = (r_jack == JACK_NONE) ? i_insert_len : i_remove_len;

    hjd_timer #(.TIMER_BITS(TIMER_BITS), .RUN_INIT(1'b1)) u_det_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_accept && det_change),
        .i_tick    (i_accept && !det_change),
        .i_len     (det_len),
        .o_expire  (det_exp)
    );

    // detect expiry handling
    always_comb begin
        jack_mid = r_jack;
        key_mid  = r_key_held;
        ign_mid  = r_ignore;
        if (det_exp) begin
            if (!i_detect) begin
                if (r_jack != JACK_NONE) begin
                    jack_mid = JACK_NONE;
                    key_mid  = 1'b0;
                end
            end else if (r_jack == JACK_NONE) begin
                ign_mid  = !i_button;
                jack_mid = i_button ? JACK_MIC : JACK_NOMIC;
            end
        end
    end

    // button change is checked against the jack state after detect handling
    assign btn_change = (jack_mid != JACK_NONE) && (i_button != r_prev_button);

    hjd_timer #(.TIMER_BITS(TIMER_BITS), .RUN_INIT(1'b0)) u_btn_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_accept && btn_change),
        .i_tick    (i_accept && !btn_change),
        .i_len     (i_button_len),
        .o_expire  (btn_exp)
    );

    always_comb begin
        n_jack     = jack_mid;
        n_key_held = key_mid;
        n_ignore   = ign_mid;
        if (btn_exp && (jack_mid == JACK_MIC) && i_detect) begin
            if (i_button) begin
                if (ign_mid) begin
                    n_ignore = 1'b0;     // first release after insert is swallowed
                end else begin
                    n_key_held = 1'b0;
                end
            end else if (!ign_mid) begin
                n_key_held = 1'b1;
            end
        end
    end

    assign changed = (n_key_held != r_key_held);

    assign o_result.jack_kind   = n_jack;
    assign o_result.key_down    = n_key_held;
    assign o_result.key_changed = changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jack        <= JACK_NONE;
            r_key_held    <= 1'b0;
            r_ignore      <= 1'b0;
            r_prev_detect <= 1'b0;
            r_prev_button <= 1'b1;
        end else if (i_accept) begin
            r_jack        <= n_jack;
            r_key_held    <= n_key_held;
            r_ignore      <= n_ignore;
            r_prev_detect <= i_detect;
            r_prev_button <= i_button;
        end
    end

`ifndef SYNTH
    a_key_needs_mic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_key_held |-> (r_jack == JACK_MIC))
        else $error("key held without a mic headset");
    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> ($stable(r_jack) && $stable(r_key_held)))
        else $error("state moved without a transaction");
    a_insert_needs_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (r_jack == JACK_NONE) && !i_detect) |=> (r_jack == JACK_NONE))
        else $error("jack inserted with detect pin low");
`endif

endmodule

FILE: hdl/headset_jack_detect_debounce_top.sv
// Top level: config registers, stream handshake and result register.
//
// Headset jack detect with button debounce.
// Input stream (s_axis): one transaction per tick, tdata[0] = detect pin,
//   tdata[1] = button pin. Output stream (m_axis): exactly one result per
//   input transaction, tdata[1:0] = jack kind, [2] = key down, [3] = key
//   changed on this tick.
// The result is in the output register in the cycle after the input transaction.
//   Throughput: one transaction per cycle unless a result stalls on m_axis_tready;
//   only the two timer counters and a few flags are updated per tick.
// Stall: s_axis_tready follows the output register; while a result waits
//   for m_axis_tready, the next input is taken in the same cycle the result
//   leaves, so no bubble appears.
// Reset (i_rst_n low, synchronous): debounce lengths return to 100/20/10
//   ticks, no jack, key released, and the detect timer is armed to expire on
//   the first tick so the pin is evaluated at once.
// Config: i_cfg_we writes i_cfg_wdata to register i_cfg_index
//   (0 insert, 1 remove, 2 button debounce ticks); write only while idle.
module headset_jack_detect_debounce_top #(
    parameter int TIMER_BITS = hjd_pkg::TIMER_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hjd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hjd_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [0] detect_pin, [1] button_pin
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [7:0]                    m_axis_tdata    // [1:0] jack_kind, [2] key_down,
                                                          // [3] key_changed
);
    import hjd_pkg::*;

    logic [CFG_W-1:0] r_insert_len, r_remove_len, r_button_len;
    logic             r_out_valid;
    t_result          r_out;
    t_result          core_result;
    logic             in_accept;

    // output register is free when empty or being drained this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_insert_len <= INSERT_TICKS_RST;
            r_remove_len <= REMOVE_TICKS_RST;
            r_button_len <= BUTTON_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_INSERT: r_insert_len <= i_cfg_wdata;
                REG_REMOVE: r_remove_len <= i_cfg_wdata;
                REG_BUTTON: r_button_len <= i_cfg_wdata;
                default: ;  // unmapped index, ignored
            endcase
        end
    end

    hjd_core #(.TIMER_BITS(TIMER_BITS)) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_detect     (s_axis_tdata[0]),
        .i_button     (s_axis_tdata[1]),
        .i_insert_len (r_insert_len),
        .i_remove_len (r_remove_len),
        .i_button_len (r_button_len),
        .o_result     (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= core_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out};

`ifndef SYNTH
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted transaction produced no result");
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input taken while result stalled");
    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && m_axis_tready && !in_accept) |=> !r_out_valid)
        else $error("result repeated after being taken");
`endif

endmodule
